### src/sswin_pkg.sv
`timescale 1ns / 1ps
// Package for the stream state and flow window block: field widths, reset
// values, the operation codes and the stream lifecycle states. No dependencies.
package sswin_pkg;

    localparam int OP_W      = 4;
    localparam int AMT_W     = 31;
    localparam int WIN_W     = 32;
    localparam int ST_W      = 3;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 1;

    // Window reset value, also the reset value of both initial window registers.
    localparam logic [CFG_W-1:0] INIT_WIN_RESET = 31'd65535;

    typedef enum logic [OP_W-1:0] {
        OP_REMOTE_UPDATE = 4'd0,
        OP_LOCAL_UPDATE  = 4'd1,
        OP_CAN_SEND      = 4'd2,
        OP_SENT          = 4'd3,
        OP_RECEIVED      = 4'd4,
        OP_OPEN          = 4'd5,
        OP_HALF_LOCAL    = 4'd6,
        OP_HALF_REMOTE   = 4'd7,
        OP_CLOSE         = 4'd8,
        OP_RESERVE_LOCAL = 4'd9,
        OP_RESERVE_REMOTE = 4'd10,
        OP_NEW_STREAM    = 4'd11
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_IDLE       = 3'd0,
        ST_RES_LOCAL  = 3'd1,
        ST_RES_REMOTE = 3'd2,
        ST_OPEN       = 3'd3,
        ST_HC_LOCAL   = 3'd4,
        ST_HC_REMOTE  = 3'd5,
        ST_CLOSED     = 3'd6
    } t_state;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_LOCAL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_REMOTE = 1'd1;

endpackage

### src/sswin_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the stream state and flow window block:
// one for event items, one for result items. Depends on sswin_pkg.
interface sswin_event_if import sswin_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [AMT_W-1:0] amount;

    modport source (output valid, output operation, output amount, input ready);
    modport sink   (input valid, input operation, input amount, output ready);
endinterface

interface sswin_result_if import sswin_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic [ST_W-1:0]         stream_state;
    logic signed [WIN_W-1:0] local_window;
    logic signed [WIN_W-1:0] remote_window;

    modport source (output valid, output ok, output stream_state, output local_window,
                    output remote_window, input ready);
    modport sink   (input valid, input ok, input stream_state, input local_window,
                    input remote_window, output ready);
endinterface

### src/stream_state_and_flow_window_top.sv
`timescale 1ns / 1ps
// Stream lifecycle and flow-control window tracker for one HTTP/2 stream.
// Depends on sswin_pkg and the channel interfaces in sswin_if.sv.

// This block follows one stream and takes one event per cycle on i_event while
// results are taken. Each accepted event transfer produces exactly one result
// on o_result, valid from the following cycle, holding the success flag, the
// lifecycle state and both signed windows as they stand after the event. The
// lifecycle and both windows are updated by a single 33-bit add or subtract per
// window and a small state decode in the cycle of the transfer. The result
// register frees itself in the cycle its transfer completes, so i_event.ready
// stays high while results are taken and drops only while a result sits
// unclaimed. The two initial window registers are written through i_cfg_we,
// i_cfg_index and i_cfg_data; they are used only by the new-stream event and
// should be written while no event is in flight.
module stream_state_and_flow_window_top import sswin_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sswin_event_if.sink          i_event,
    sswin_result_if.source       o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // Configuration registers.
    logic [CFG_W-1:0] r_init_local;
    logic [CFG_W-1:0] r_init_remote;

    // Stream state.
    t_state                  r_state, n_state;
    logic signed [WIN_W-1:0] r_local, n_local;
    logic signed [WIN_W-1:0] r_remote, n_remote;
    logic                    n_ok;

    // Result register.
    logic                    r_out_valid;
    logic                    r_out_ok;
    t_state                  r_out_state;
    logic signed [WIN_W-1:0] r_out_local;
    logic signed [WIN_W-1:0] r_out_remote;

    logic w_accept;

    // Window arithmetic is done one bit wider so that sums and differences
    // never wrap; bits 32 and 31 then tell overflow and underflow.
    logic signed [WIN_W:0] w_amt_x;
    logic signed [WIN_W:0] w_local_add, w_remote_add;
    logic signed [WIN_W:0] w_local_sub, w_remote_sub;
    logic                  w_local_ovf, w_remote_ovf;
    logic                  w_local_unf, w_remote_unf;

    assign i_event.ready = !r_out_valid || o_result.ready;
    assign w_accept      = i_event.valid && i_event.ready;

    assign w_amt_x      = $signed({2'b00, i_event.amount});
    assign w_local_add  = $signed({r_local[WIN_W-1], r_local}) + w_amt_x;
    assign w_remote_add = $signed({r_remote[WIN_W-1], r_remote}) + w_amt_x;
    assign w_local_sub  = $signed({r_local[WIN_W-1], r_local}) - w_amt_x;
    assign w_remote_sub = $signed({r_remote[WIN_W-1], r_remote}) - w_amt_x;

    // A sum above the largest positive window shows as a positive 33-bit value
    // with bit 31 set; a difference below the most negative window as the mirror.
    assign w_local_ovf  = !w_local_add[WIN_W] && w_local_add[WIN_W-1];
    assign w_remote_ovf = !w_remote_add[WIN_W] && w_remote_add[WIN_W-1];
    assign w_local_unf  = w_local_sub[WIN_W] && !w_local_sub[WIN_W-1];
    assign w_remote_unf = w_remote_sub[WIN_W] && !w_remote_sub[WIN_W-1];

    always_comb begin
        n_state  = r_state;
        n_local  = r_local;
        n_remote = r_remote;
        n_ok     = 1'b1;
        case (t_op'(i_event.operation))
            OP_REMOTE_UPDATE: begin
                // A refused update leaves the window as it was.
                n_ok = !w_remote_ovf;
                if (!w_remote_ovf) begin
                    n_remote = w_remote_add[WIN_W-1:0];
                end
            end
            OP_LOCAL_UPDATE: begin
                n_ok = !w_local_ovf;
                if (!w_local_ovf) begin
                    n_local = w_local_add[WIN_W-1:0];
                end
            end
            OP_CAN_SEND: begin
                // Sending is allowed only on a stream that may still carry data
                // out and whose remote window covers the amount.
                n_ok = (r_state == ST_OPEN || r_state == ST_HC_REMOTE) &&
                       !w_remote_sub[WIN_W];
            end
            OP_SENT: begin
                n_remote = w_remote_unf ? {1'b1, {(WIN_W-1){1'b0}}} : w_remote_sub[WIN_W-1:0];
            end
            OP_RECEIVED: begin
                n_local = w_local_unf ? {1'b1, {(WIN_W-1){1'b0}}} : w_local_sub[WIN_W-1:0];
            end
            OP_OPEN: begin
                if (r_state == ST_IDLE || r_state == ST_RES_LOCAL ||
                    r_state == ST_RES_REMOTE) begin
                    n_state = ST_OPEN;
                end
            end
            OP_HALF_LOCAL: begin
                if (r_state == ST_OPEN || r_state == ST_RES_LOCAL) begin
                    n_state = ST_HC_LOCAL;
                end else if (r_state == ST_HC_REMOTE) begin
                    n_state = ST_CLOSED;
                end
            end
            OP_HALF_REMOTE: begin
                if (r_state == ST_OPEN || r_state == ST_RES_REMOTE) begin
                    n_state = ST_HC_REMOTE;
                end else if (r_state == ST_HC_LOCAL) begin
                    n_state = ST_CLOSED;
                end
            end
            OP_CLOSE: begin
                n_state  = ST_CLOSED;
                n_local  = '0;
                n_remote = '0;
            end
            OP_RESERVE_LOCAL: begin
                if (r_state == ST_IDLE) begin
                    n_state = ST_RES_LOCAL;
                end
            end
            OP_RESERVE_REMOTE: begin
                if (r_state == ST_IDLE) begin
                    n_state = ST_RES_REMOTE;
                end
            end
            OP_NEW_STREAM: begin
                n_state  = ST_IDLE;
                n_local  = $signed({1'b0, r_init_local});
                n_remote = $signed({1'b0, r_init_remote});
            end
            default: begin
                // Unassigned operation codes change nothing and report success.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_local  <= INIT_WIN_RESET;
            r_init_remote <= INIT_WIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INIT_LOCAL:  r_init_local  <= i_cfg_data;
                CFG_INIT_REMOTE: r_init_remote <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_local  <= $signed({1'b0, INIT_WIN_RESET});
            r_remote <= $signed({1'b0, INIT_WIN_RESET});
        end else if (w_accept) begin
            r_state  <= n_state;
            r_local  <= n_local;
            r_remote <= n_remote;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_ok     <= n_ok;
            r_out_state  <= n_state;
            r_out_local  <= n_local;
            r_out_remote <= n_remote;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.ok            = r_out_ok;
    assign o_result.stream_state  = r_out_state;
    assign o_result.local_window  = r_out_local;
    assign o_result.remote_window = r_out_remote;

endmodule

### src/sswin_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the stream state and flow window top level, attached by
// the bind below. Depends on sswin_pkg and stream_state_and_flow_window_top.
module sswin_checker import sswin_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_ev_valid,
    input logic                    i_ev_ready,
    input logic [OP_W-1:0]         i_ev_operation,
    input logic                    i_res_valid,
    input logic                    i_res_ready,
    input logic                    i_res_ok,
    input logic [ST_W-1:0]         i_res_state,
    input logic signed [WIN_W-1:0] i_res_local,
    input logic signed [WIN_W-1:0] i_res_remote
);

    logic w_ev_xfer;
    assign w_ev_xfer = i_ev_valid && i_ev_ready;

    // A result waiting on a stalled sink keeps its contents.
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
        i_res_valid && $stable(i_res_ok) && $stable(i_res_state) &&
        $stable(i_res_local) && $stable(i_res_remote))
        else $error("result changed while stalled");

    // No new event may enter while the only result slot is stalled.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |-> !w_ev_xfer)
        else $error("event taken while result stalled");

    // A close event shows next cycle as a closed stream with empty windows.
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ev_xfer && i_ev_operation == OP_CLOSE |=>
        i_res_valid && i_res_state == ST_CLOSED && i_res_local == '0 &&
        i_res_remote == '0 && i_res_ok)
        else $error("close event result wrong");

    // A new-stream event always returns the stream to idle.
    a_new_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ev_xfer && i_ev_operation == OP_NEW_STREAM |=>
        i_res_valid && i_res_state == ST_IDLE && i_res_ok)
        else $error("new stream result wrong");

endmodule

bind stream_state_and_flow_window_top sswin_checker u_sswin_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_ev_valid     (i_event.valid),
    .i_ev_ready     (i_event.ready),
    .i_ev_operation (i_event.operation),
    .i_res_valid    (o_result.valid),
    .i_res_ready    (o_result.ready),
    .i_res_ok       (o_result.ok),
    .i_res_state    (o_result.stream_state),
    .i_res_local    (o_result.local_window),
    .i_res_remote   (o_result.remote_window)
);

### verif/sswin_flow_checker.sv
`timescale 1ns / 1ps
// Checker for the stream state and flow window block: watches both channels and
// the window register port, predicts every result and compares it field by field.
// Depends on sswin_pkg and the channel interfaces in sswin_if.sv.
module sswin_flow_checker import sswin_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sswin_event_if               i_event_mon,
    sswin_result_if              i_result_mon,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_reports_due,
    output int                   o_fail_count
);

    localparam longint WIN_CEIL  = (64'sd1 <<< 31) - 64'sd1;
    localparam longint WIN_FLOOR = -(64'sd1 <<< 31);
    localparam int     REPORT_LIMIT = 10;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic                    ok;
        logic [ST_W-1:0]         st;
        logic signed [WIN_W-1:0] lw;
        logic signed [WIN_W-1:0] rw;
    } stream_report_t;

    // Shadow copy of the stream as the block should hold it.
    t_state                  lifecycle;
    logic signed [WIN_W-1:0] local_credit;
    logic signed [WIN_W-1:0] remote_credit;
    logic [CFG_W-1:0]        init_local_win;
    logic [CFG_W-1:0]        init_remote_win;

    stream_report_t reports_due[$];
    int             fails;

    // A window update is refused when the sum would pass the signed maximum.
    function automatic logic credit_window(inout logic signed [WIN_W-1:0] win,
                                           input logic [AMT_W-1:0] inc);
        longint sum;
        sum = longint'(win) + longint'(inc);
        if (inc == '0) begin
            return 1'b1;
        end
        if (sum > WIN_CEIL) begin
            return 1'b0;
        end
        win = sum[WIN_W-1:0];
        return 1'b1;
    endfunction

    function automatic void debit_window(inout logic signed [WIN_W-1:0] win,
                                         input logic [AMT_W-1:0] amt);
        longint diff;
        diff = longint'(win) - longint'(amt);
        if (diff < WIN_FLOOR) begin
            diff = WIN_FLOOR;
        end
        win = diff[WIN_W-1:0];
    endfunction

    function automatic stream_report_t advance_stream(input logic [OP_W-1:0] op,
                                                      input logic [AMT_W-1:0] amt);
        stream_report_t r;
        logic           ok;
        ok = 1'b1;
        case (op)
            OP_REMOTE_UPDATE: ok = credit_window(remote_credit, amt);
            OP_LOCAL_UPDATE:  ok = credit_window(local_credit, amt);
            OP_CAN_SEND: begin
                ok = (lifecycle == ST_OPEN || lifecycle == ST_HC_REMOTE) &&
                     (longint'(remote_credit) >= longint'(amt));
            end
            OP_SENT:     debit_window(remote_credit, amt);
            OP_RECEIVED: debit_window(local_credit, amt);
            OP_OPEN: begin
                if (lifecycle == ST_IDLE || lifecycle == ST_RES_LOCAL ||
                    lifecycle == ST_RES_REMOTE) begin
                    lifecycle = ST_OPEN;
                end
            end
            OP_HALF_LOCAL: begin
                if (lifecycle == ST_OPEN || lifecycle == ST_RES_LOCAL) begin
                    lifecycle = ST_HC_LOCAL;
                end else if (lifecycle == ST_HC_REMOTE) begin
                    lifecycle = ST_CLOSED;
                end
            end
            OP_HALF_REMOTE: begin
                if (lifecycle == ST_OPEN || lifecycle == ST_RES_REMOTE) begin
                    lifecycle = ST_HC_REMOTE;
                end else if (lifecycle == ST_HC_LOCAL) begin
                    lifecycle = ST_CLOSED;
                end
            end
            OP_CLOSE: begin
                lifecycle     = ST_CLOSED;
                local_credit  = '0;
                remote_credit = '0;
            end
            OP_RESERVE_LOCAL: begin
                if (lifecycle == ST_IDLE) begin
                    lifecycle = ST_RES_LOCAL;
                end
            end
            OP_RESERVE_REMOTE: begin
                if (lifecycle == ST_IDLE) begin
                    lifecycle = ST_RES_REMOTE;
                end
            end
            OP_NEW_STREAM: begin
                lifecycle     = ST_IDLE;
                local_credit  = {1'b0, init_local_win};
                remote_credit = {1'b0, init_remote_win};
            end
            default: ;
        endcase
        r.op = op;
        r.ok = ok;
        r.st = lifecycle;
        r.lw = local_credit;
        r.rw = remote_credit;
        return r;
    endfunction

    always @(posedge i_clk) begin
        stream_report_t want;
        if (!i_rst_n) begin
            lifecycle       = ST_IDLE;
            local_credit    = {1'b0, INIT_WIN_RESET};
            remote_credit   = {1'b0, INIT_WIN_RESET};
            init_local_win  = INIT_WIN_RESET;
            init_remote_win = INIT_WIN_RESET;
            fails           = 0;
            reports_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_INIT_LOCAL) begin
                    init_local_win = i_cfg_data;
                end else if (i_cfg_index == CFG_INIT_REMOTE) begin
                    init_remote_win = i_cfg_data;
                end
            end
            // The result side is handled first: a result can never belong to
            // an event accepted at the same edge.
            if (i_result_mon.valid && i_result_mon.ready) begin
                if (reports_due.size() == 0) begin
                    if (fails < REPORT_LIMIT) begin
                        $display("%0t: result transfer with nothing outstanding", $realtime);
                    end
                    fails++;
                end else begin
                    want = reports_due.pop_front();
                    if (i_result_mon.ok !== want.ok || i_result_mon.stream_state !== want.st ||
                        i_result_mon.local_window !== want.lw ||
                        i_result_mon.remote_window !== want.rw) begin
                        if (fails < REPORT_LIMIT) begin
                            $display("%0t: op %0d expected ok=%0b st=%0d lw=%0d rw=%0d, got ok=%0b st=%0d lw=%0d rw=%0d",
                                     $realtime, want.op, want.ok, want.st, want.lw, want.rw,
                                     i_result_mon.ok, i_result_mon.stream_state,
                                     i_result_mon.local_window, i_result_mon.remote_window);
                        end
                        fails++;
                    end
                end
            end
            if (i_event_mon.valid && i_event_mon.ready) begin
                reports_due.push_back(advance_stream(i_event_mon.operation,
                                                     i_event_mon.amount));
            end
        end
        o_reports_due <= reports_due.size();
        o_fail_count  <= fails;
    end

endmodule

### verif/tb_stream_state_and_flow_window_top.sv
`timescale 1ns / 1ps
// Testbench top for the stream state and flow window block: clock, reset,
// event stimulus, result back-pressure and the verdict. Depends on sswin_pkg,
// the channel interfaces in sswin_if.sv and the sswin_flow_checker module.
module tb_stream_state_and_flow_window_top;
    import sswin_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int LIMIT_CYCLES = 250000;
    localparam int LONG_HOLD    = 200;
    localparam int PHASE_ITEMS  = 280;
    localparam int MAX_WAIT     = 8;

    localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};
    localparam logic [CFG_W-1:0] WIN_REG_MAX = {CFG_W{1'b1}};

    // Operation codes that the block has no meaning for; it must leave the
    // stream alone and report success.
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 4'd12;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 4'd15;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int reports_due;
    int fail_count;
    int cycle_count;
    int events_sent;

    // Calm modes give stretches in which a side never idles; the hold request
    // asks the result side for one long stall while events keep coming.
    bit sender_calm;
    bit receiver_calm;
    bit hold_request;

    sswin_event_if  event_ch();
    sswin_result_if result_ch();

    stream_state_and_flow_window_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_event     (event_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    sswin_flow_checker u_flow_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_event_mon   (event_ch),
        .i_result_mon  (result_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_reports_due (reports_due),
        .o_fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog. A correct run ends well within this budget, even
    // with every item waiting out the longest gap and the longest stall.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Result side. Before each transfer it draws a random stall, or none while in
    // calm mode, or the long hold when one has been requested. Ready then stays
    // high until a transfer happens.
    initial begin
        int stall;
        result_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = receiver_calm ? 0 : $urandom_range(0, MAX_WAIT);
                if ($urandom_range(0, 39) == 0) begin
                    receiver_calm = !receiver_calm;
                end
            end
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!result_ch.valid);
        end
    end

    // Offers one event and returns at the edge where its transfer happens.
    // Valid is only lowered when a gap is drawn, so back-to-back events keep
    // it high without a glitch.
    task automatic send_event(input logic [OP_W-1:0] op, input logic [AMT_W-1:0] amt);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 39) == 0) begin
            sender_calm = !sender_calm;
        end
        if (gap > 0) begin
            event_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        event_ch.valid     <= 1'b1;
        event_ch.operation <= op;
        event_ch.amount    <= amt;
        do @(posedge i_clk); while (!event_ch.ready);
        events_sent++;
    endtask

    // Amounts cluster where the interesting boundaries are: zero, small data
    // counts, values near the 65535 default window, and values near the top of
    // the window range. Full-range values make every amount bit toggle.
    function automatic logic [AMT_W-1:0] pick_amount();
        case ($urandom_range(0, 7))
            0:       return '0;
            1, 2:    return AMT_W'($urandom_range(1, 2000));
            3:       return AMT_W'($urandom_range(60000, 70000));
            4:       return AMT_MAX;
            5:       return AMT_MAX - AMT_W'($urandom_range(0, 70000));
            default: return AMT_W'($urandom);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_flow_op();
        case ($urandom_range(0, 4))
            0:       return OP_REMOTE_UPDATE;
            1:       return OP_LOCAL_UPDATE;
            2:       return OP_CAN_SEND;
            3:       return OP_SENT;
            default: return OP_RECEIVED;
        endcase
    endfunction

    // An event inside a stream session. Now and then a stray event with any
    // operation code, the unused ones included, is slipped in before it.
    task automatic session_event(input logic [OP_W-1:0] op, input logic [AMT_W-1:0] amt);
        if ($urandom_range(0, 7) == 0) begin
            send_event(OP_W'($urandom_range(0, 15)), AMT_W'($urandom));
        end
        send_event(op, amt);
    endtask

    task automatic flow_traffic(input int lo, input int hi);
        repeat ($urandom_range(lo, hi)) session_event(pick_flow_op(), pick_amount());
    endtask

    // A well-formed stream life: new stream, maybe a reservation, usually an open,
    // flow traffic, then one of the ways a stream ends (or no end at all, so that
    // the next new-stream event cuts it off).
    task automatic stream_session();
        session_event(OP_NEW_STREAM, pick_amount());
        case ($urandom_range(0, 3))
            0:       session_event(OP_RESERVE_LOCAL, pick_amount());
            1:       session_event(OP_RESERVE_REMOTE, pick_amount());
            default: ;
        endcase
        if ($urandom_range(0, 9) != 0) begin
            session_event(OP_OPEN, pick_amount());
        end
        flow_traffic(2, 16);
        case ($urandom_range(0, 3))
            0: begin
                session_event(OP_HALF_LOCAL, pick_amount());
                flow_traffic(0, 4);
                session_event(OP_HALF_REMOTE, pick_amount());
            end
            1: begin
                session_event(OP_HALF_REMOTE, pick_amount());
                flow_traffic(0, 4);
                session_event(OP_HALF_LOCAL, pick_amount());
            end
            2: session_event(OP_CLOSE, pick_amount());
            default: ;
        endcase
        flow_traffic(0, 3);
    endtask

    task automatic random_sessions(input int quota);
        int start;
        start = events_sent;
        while (events_sent - start < quota) stream_session();
    endtask

    // Stops offering events and waits until every result has been taken. The
    // first edge lets the outstanding count catch up with the last transfer.
    task automatic settle();
        event_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (reports_due != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_windows(input logic [CFG_W-1:0] local_win,
                                   input logic [CFG_W-1:0] remote_win);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INIT_LOCAL;
        cfg_data  <= local_win;
        @(posedge i_clk);
        cfg_index <= CFG_INIT_REMOTE;
        cfg_data  <= remote_win;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Directed opening with the reset window of 65535 on both sides.
    task automatic directed_run();
        // A zero increment succeeds without change, and an increment past
        // the signed maximum is refused.
        send_event(OP_REMOTE_UPDATE, '0);
        send_event(OP_REMOTE_UPDATE, AMT_MAX);
        // Landing exactly on the maximum is allowed; one more is not.
        send_event(OP_LOCAL_UPDATE, AMT_MAX - AMT_W'(65535));
        send_event(OP_LOCAL_UPDATE, AMT_W'(1));
        // Sending is never allowed from idle.
        send_event(OP_CAN_SEND, '0);
        send_event(OP_OPEN, '0);
        // The remote window bound is inclusive.
        send_event(OP_CAN_SEND, AMT_W'(65535));
        send_event(OP_CAN_SEND, AMT_W'(65536));
        // Two large debits drive the remote window into saturation.
        send_event(OP_SENT, AMT_MAX);
        send_event(OP_SENT, AMT_MAX);
        send_event(OP_RECEIVED, '0);
        send_event(OP_HALF_LOCAL, '0);
        send_event(OP_OPEN, '0);
        send_event(OP_HALF_REMOTE, '0);
        send_event(OP_RESERVE_LOCAL, '0);
        send_event(OP_NEW_STREAM, '0);
        send_event(OP_RESERVE_REMOTE, '0);
        send_event(OP_HALF_LOCAL, '0);
        send_event(OP_HALF_REMOTE, '0);
        send_event(OP_HALF_LOCAL, '0);
        send_event(OP_NEW_STREAM, AMT_MAX);
        send_event(OP_RESERVE_LOCAL, '0);
        send_event(OP_HALF_LOCAL, '0);
        send_event(OP_CLOSE, AMT_MAX);
        send_event(OP_UNUSED_FIRST, AMT_MAX);
        send_event(OP_UNUSED_LAST, '0);
    endtask

    // Main sequence: reset, the directed opening, then random phases, each
    // with its own pair of initial windows, extremes included. Registers are
    // only written once the block has drained.
    initial begin
        event_ch.valid     <= 1'b0;
        event_ch.operation <= OP_REMOTE_UPDATE;
        event_ch.amount    <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_INIT_LOCAL;
        cfg_data           <= '0;
        i_rst_n            <= 1'b0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        hold_request  = 1'b0;
        events_sent   = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_run();
        random_sessions(PHASE_ITEMS);
        settle();

        program_windows('0, WIN_REG_MAX);
        random_sessions(PHASE_ITEMS);
        settle();

        // The result side stalls for a long stretch in this phase, so the
        // block fills and has to hold off the event side.
        program_windows(WIN_REG_MAX, '0);
        hold_request = 1'b1;
        random_sessions(PHASE_ITEMS);
        settle();

        program_windows(CFG_W'($urandom), CFG_W'($urandom));
        random_sessions(PHASE_ITEMS);
        settle();

        program_windows(CFG_W'($urandom_range(0, 100000)), CFG_W'($urandom_range(0, 100000)));
        hold_request = 1'b1;
        random_sessions(PHASE_ITEMS);
        settle();

        program_windows(WIN_REG_MAX, WIN_REG_MAX);
        random_sessions(PHASE_ITEMS);
        settle();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
